@@ design/twq_pkg.sv @@
// Shared types, constants and helpers of the timed wake queue.
`default_nettype none

package twq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 6;
    localparam int PRIO_W      = 6;
    localparam int TIME_W      = 32;

    typedef logic [PTR_W-1:0] twq_ptr_t;
    typedef logic [CNT_W-1:0] twq_cnt_t;

    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } twq_op_t;

    typedef struct packed {
        twq_op_t           op;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] key_time;
        logic [PRIO_W-1:0] prio;
    } twq_cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   task_id;
    } twq_entry_t;

    localparam int ENTRY_W = $bits(twq_entry_t);

    typedef struct packed {
        logic            woken_valid;
        logic [ID_W-1:0] woken_id;
        logic            queue_full;
        logic            last_result;
    } twq_result_t;

    function automatic twq_ptr_t wrap_add(input twq_ptr_t base, input twq_ptr_t off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/twq_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module twq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

@@ design/twq_front.sv @@
// Input side: accepts commands, classifies them and buffers them for the engine.
`default_nettype none

module twq_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          cmd,
    input  wire logic [twq_pkg::ID_W-1:0]      task_id,
    input  wire logic [twq_pkg::TIME_W-1:0]    wake_time,
    input  wire logic [twq_pkg::PRIO_W-1:0]    task_priority,
    input  wire logic [twq_pkg::TIME_W-1:0]    now_time,
    output logic                               item_valid,
    output twq_pkg::twq_cmd_t                  item,
    input  wire logic                          item_take
);

    twq_pkg::twq_cmd_t mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    twq_pkg::twq_cmd_t in_item;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        in_item.op       = cmd ? twq_pkg::OP_TICK : twq_pkg::OP_SLEEP;
        in_item.task_id  = task_id;
        in_item.key_time = cmd ? now_time : wake_time;
        in_item.prio     = task_priority;
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ design/twq_result_q.sv @@
// Output side: buffers results until the receiver pops them.
`default_nettype none

module twq_result_q (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     res_push,
    input  wire twq_pkg::twq_result_t     res_data,
    output logic                          res_full,
    output logic                          empty,
    input  wire logic                     pop,
    output twq_pkg::twq_result_t          head
);

    twq_pkg::twq_result_t mem_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = mem_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

`default_nettype wire

@@ design/twq_engine.sv @@
// Back end: keeps the sorted entry ring in RAM and runs sorted insert and due pop.
`default_nettype none

module twq_engine (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire twq_pkg::twq_cmd_t     item,
    output logic                       item_take,
    output logic                       res_push,
    output twq_pkg::twq_result_t       res_data,
    input  wire logic                  res_full
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_INS_SCAN  = 5'b00010,
        S_INS_PLACE = 5'b00100,
        S_POP_EVAL  = 5'b01000,
        S_FINISH    = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    twq_pkg::twq_ptr_t              head_reg, head_next;
    twq_pkg::twq_cnt_t              count_reg, count_next;
    twq_pkg::twq_ptr_t              idx_reg, idx_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic                           full_flag_reg, full_flag_next;
    logic [twq_pkg::ID_W-1:0]       pend_id_reg, pend_id_next;
    twq_pkg::twq_cmd_t              cur_reg, cur_next;

    logic                           wr_en;
    twq_pkg::twq_ptr_t              wr_addr;
    twq_pkg::twq_entry_t            wr_data;
    twq_pkg::twq_ptr_t              rd_addr;
    logic [twq_pkg::ENTRY_W-1:0]    rd_word;
    twq_pkg::twq_entry_t            rd_entry;
    twq_pkg::twq_entry_t            new_entry;
    twq_pkg::twq_entry_t            item_entry;
    logic                           goes_first;
    logic                           is_due;
    logic                           q_full;
    twq_pkg::twq_ptr_t              head_inc;

    twq_ram #(
        .WIDTH (twq_pkg::ENTRY_W),
        .DEPTH (twq_pkg::QUEUE_DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = rd_word;

    always_comb
    begin
        new_entry.wake     = cur_reg.key_time;
        new_entry.prio     = cur_reg.prio;
        new_entry.task_id  = cur_reg.task_id;
        item_entry.wake    = item.key_time;
        item_entry.prio    = item.prio;
        item_entry.task_id = item.task_id;
    end

    assign goes_first = (cur_reg.key_time < rd_entry.wake) ||
                        ((cur_reg.key_time == rd_entry.wake) && (cur_reg.prio > rd_entry.prio));
    assign is_due     = (rd_entry.wake <= cur_reg.key_time);
    assign q_full     = (count_reg == twq_pkg::CNT_W'(twq_pkg::QUEUE_DEPTH));
    assign head_inc   = twq_pkg::wrap_add(head_reg, twq_pkg::PTR_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        full_flag_next  = full_flag_reg;
        pend_id_next    = pend_id_reg;
        cur_next        = cur_reg;
        item_take       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = new_entry;
        rd_addr         = head_reg;
        res_push        = 1'b0;
        res_data        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_take       = 1'b1;
                    cur_next        = item;
                    pend_valid_next = 1'b0;
                    full_flag_next  = 1'b0;
                    if (item.op == twq_pkg::OP_TICK)
                    begin
                        rd_addr    = head_reg;
                        state_next = (count_reg == '0) ? S_FINISH : S_POP_EVAL;
                    end
                    else if (q_full)
                    begin
                        full_flag_next = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_reg;
                        wr_data    = item_entry;
                        count_next = count_reg + twq_pkg::CNT_W'(1);
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = twq_pkg::PTR_W'(count_reg - twq_pkg::CNT_W'(1));
                        rd_addr    = twq_pkg::wrap_add(head_reg, idx_next);
                        state_next = S_INS_SCAN;
                    end
                end
            end

            S_INS_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = twq_pkg::wrap_add(head_reg, idx_reg + twq_pkg::PTR_W'(1));
                if (goes_first)
                begin
                    wr_data = rd_entry;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PLACE;
                    end
                    else
                    begin
                        idx_next = idx_reg - twq_pkg::PTR_W'(1);
                        rd_addr  = twq_pkg::wrap_add(head_reg, idx_next);
                    end
                end
                else
                begin
                    wr_data    = new_entry;
                    count_next = count_reg + twq_pkg::CNT_W'(1);
                    state_next = S_FINISH;
                end
            end

            S_INS_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                wr_data    = new_entry;
                count_next = count_reg + twq_pkg::CNT_W'(1);
                state_next = S_FINISH;
            end

            S_POP_EVAL:
            begin
                rd_addr = head_reg;
                if (!is_due)
                begin
                    state_next = S_FINISH;
                end
                else if (!pend_valid_reg || !res_full)
                begin
                    res_push             = pend_valid_reg;
                    res_data.woken_valid = 1'b1;
                    res_data.woken_id    = pend_id_reg;
                    pend_valid_next      = 1'b1;
                    pend_id_next         = rd_entry.task_id;
                    head_next            = head_inc;
                    count_next           = count_reg - twq_pkg::CNT_W'(1);
                    rd_addr              = head_inc;
                    if (count_reg == twq_pkg::CNT_W'(1))
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                res_data.woken_valid = pend_valid_reg;
                res_data.woken_id    = pend_valid_reg ? pend_id_reg : '0;
                res_data.queue_full  = full_flag_reg;
                res_data.last_result = 1'b1;
                if (!res_full)
                begin
                    res_push        = 1'b1;
                    pend_valid_next = 1'b0;
                    full_flag_next  = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            full_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            full_flag_reg  <= full_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        pend_id_reg <= pend_id_next;
        cur_reg     <= cur_next;
    end

endmodule

`default_nettype wire

@@ design/timed_wake_queue_core.sv @@
// Top level of the timed wake queue: sorted sleep queue with tick-driven wakeup.
//
// Input channel: a transaction is taken on a rising edge with push high and full low.
// cmd 0 inserts task_id with wake_time and task_priority in order (earlier wake
// first, then higher priority, equal keys in arrival order); cmd 1 pops every
// entry whose wake tick is at or before now_time.
// Result channel: while empty is low the oldest result is on the result ports;
// it is taken on a rising edge with pop high. A sleep gives one result (queue_full
// set when the entry was dropped); a tick gives one result per woken task, the
// last one marked, or one empty result when nothing is due.
// The entries live in a ring buffer in one RAM; a tick advances the head pointer,
// a sleep walks from the tail toward the head moving one entry per cycle.
// A sleep runs longer the more entries move, and a tick the more entries it wakes.
// One command is worked on at a time; two more wait in the input buffer.
// Reset empties the queue and both buffers; RAM contents need no clearing.
// A stalled receiver fills the two-entry result buffer and then holds the engine,
// which in turn fills the input buffer and raises full.
`default_nettype none

module timed_wake_queue_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          cmd,
    input  wire logic [twq_pkg::ID_W-1:0]      task_id,
    input  wire logic [twq_pkg::TIME_W-1:0]    wake_time,
    input  wire logic [twq_pkg::PRIO_W-1:0]    task_priority,
    input  wire logic [twq_pkg::TIME_W-1:0]    now_time,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               woken_valid,
    output logic      [twq_pkg::ID_W-1:0]      woken_id,
    output logic                               queue_full,
    output logic                               last_result
);

    logic                  item_valid;
    twq_pkg::twq_cmd_t     item;
    logic                  item_take;
    logic                  res_push;
    twq_pkg::twq_result_t  res_data;
    logic                  res_full;
    twq_pkg::twq_result_t  head;

    twq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .task_id       (task_id),
        .wake_time     (wake_time),
        .task_priority (task_priority),
        .now_time      (now_time),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    twq_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_push   (res_push),
        .res_data   (res_data),
        .res_full   (res_full)
    );

    twq_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign woken_valid = head.woken_valid;
    assign woken_id    = head.woken_id;
    assign queue_full  = head.queue_full;
    assign last_result = head.last_result;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench of the timed wake queue core: directed, full, stall and random runs.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES = 2 * twq_pkg::QUEUE_DEPTH + 16;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       push          = 1'b0;
    logic                       full;
    logic                       cmd           = twq_pkg::OP_SLEEP;
    logic [twq_pkg::ID_W-1:0]   task_id       = '0;
    logic [twq_pkg::TIME_W-1:0] wake_time     = '0;
    logic [twq_pkg::PRIO_W-1:0] task_priority = '0;
    logic [twq_pkg::TIME_W-1:0] now_time      = '0;
    logic                       empty;
    logic                       pop           = 1'b0;
    logic                       woken_valid;
    logic [twq_pkg::ID_W-1:0]   woken_id;
    logic                       queue_full;
    logic                       last_result;

    timed_wake_queue_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .task_id       (task_id),
        .wake_time     (wake_time),
        .task_priority (task_priority),
        .now_time      (now_time),
        .empty         (empty),
        .pop           (pop),
        .woken_valid   (woken_valid),
        .woken_id      (woken_id),
        .queue_full    (queue_full),
        .last_result   (last_result)
    );

    // sorted sleep list mirrored by the testbench
    logic [twq_pkg::TIME_W-1:0] sleep_wake [twq_pkg::QUEUE_DEPTH];
    logic [twq_pkg::PRIO_W-1:0] sleep_prio [twq_pkg::QUEUE_DEPTH];
    logic [twq_pkg::ID_W-1:0]   sleep_task [twq_pkg::QUEUE_DEPTH];
    int                         sleep_count = 0;

    twq_pkg::twq_result_t       wakeups_due[$];

    int                         errors      = 0;
    int                         cycle_count = 0;
    int                         n_sleep     = 0;
    int                         n_dropped   = 0;
    int                         n_tick      = 0;
    int                         n_woken     = 0;
    int                         n_idle_tick = 0;
    int                         n_checked   = 0;
    bit                         idle_on     = 1'b1;
    int                         hold_req    = 0;
    int                         hold_left   = 0;
    int                         stall_left  = 0;
    logic [twq_pkg::TIME_W-1:0] clock_now   = '0;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d transactions outstanding",
                     $time, wakeups_due.size());
            $display("timed_wake_queue_core regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [twq_pkg::ID_W-1:0] rand_id();
        return twq_pkg::ID_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [twq_pkg::PRIO_W-1:0] rand_prio(input int hi);
        return twq_pkg::PRIO_W'($urandom_range(0, hi));
    endfunction

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (!idle_on)
        begin
            pop <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        twq_pkg::twq_result_t got;
        twq_pkg::twq_result_t want;
        if (rst_n && pop && !empty)
        begin
            got = '{woken_valid, woken_id, queue_full, last_result};
            if (wakeups_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result valid=%0b id=%0d full=%0b last=%0b",
                         $time, got.woken_valid, got.woken_id, got.queue_full,
                         got.last_result);
            end
            else
            begin
                want = wakeups_due.pop_front();
                n_checked++;
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch expected valid=%0b id=%0d full=%0b last=%0b",
                             $time, want.woken_valid, want.woken_id, want.queue_full,
                             want.last_result);
                    $display("%0t:          actual   valid=%0b id=%0d full=%0b last=%0b",
                             $time, got.woken_valid, got.woken_id, got.queue_full,
                             got.last_result);
                end
            end
        end
    end

    task automatic predict_sleep(input logic [twq_pkg::ID_W-1:0] id,
                                 input logic [twq_pkg::TIME_W-1:0] w,
                                 input logic [twq_pkg::PRIO_W-1:0] p);
        twq_pkg::twq_result_t r;
        int                   pos;
        r = '0;
        r.last_result = 1'b1;
        n_sleep++;
        if (sleep_count >= twq_pkg::QUEUE_DEPTH)
        begin
            r.queue_full = 1'b1;
            n_dropped++;
        end
        else
        begin
            pos = sleep_count;
            for (int i = 0; i < sleep_count; i++)
            begin
                if (w < sleep_wake[i] || (w == sleep_wake[i] && p > sleep_prio[i]))
                begin
                    pos = i;
                    break;
                end
            end
            for (int i = sleep_count; i > pos; i--)
            begin
                sleep_wake[i] = sleep_wake[i-1];
                sleep_prio[i] = sleep_prio[i-1];
                sleep_task[i] = sleep_task[i-1];
            end
            sleep_wake[pos] = w;
            sleep_prio[pos] = p;
            sleep_task[pos] = id;
            sleep_count++;
        end
        wakeups_due.push_back(r);
    endtask

    task automatic predict_tick(input logic [twq_pkg::TIME_W-1:0] now);
        twq_pkg::twq_result_t r;
        int                   due;
        due = 0;
        n_tick++;
        while (due < sleep_count && sleep_wake[due] <= now)
            due++;
        if (due == 0)
        begin
            r = '0;
            r.last_result = 1'b1;
            n_idle_tick++;
            wakeups_due.push_back(r);
        end
        else
        begin
            for (int i = 0; i < due; i++)
            begin
                r = '0;
                r.woken_valid = 1'b1;
                r.woken_id    = sleep_task[i];
                r.last_result = (i == due - 1);
                wakeups_due.push_back(r);
                n_woken++;
            end
            for (int i = due; i < sleep_count; i++)
            begin
                sleep_wake[i-due] = sleep_wake[i];
                sleep_prio[i-due] = sleep_prio[i];
                sleep_task[i-due] = sleep_task[i];
            end
            sleep_count -= due;
        end
    endtask

    task automatic send_item(input twq_pkg::twq_op_t op,
                             input logic [twq_pkg::ID_W-1:0] id,
                             input logic [twq_pkg::TIME_W-1:0] wake,
                             input logic [twq_pkg::PRIO_W-1:0] prio,
                             input logic [twq_pkg::TIME_W-1:0] now);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push          <= 1'b1;
        cmd           <= op;
        task_id       <= id;
        wake_time     <= wake;
        task_priority <= prio;
        now_time      <= now;
        do
        begin
            @(posedge clk);
        end
        while (full);
        if (op == twq_pkg::OP_SLEEP)
            predict_sleep(id, wake, prio);
        else
            predict_tick(now);
    endtask

    task automatic sleep_task_on(input logic [twq_pkg::ID_W-1:0] id,
                                 input logic [twq_pkg::TIME_W-1:0] wake,
                                 input logic [twq_pkg::PRIO_W-1:0] prio);
        send_item(twq_pkg::OP_SLEEP, id, wake, prio, $urandom);
    endtask

    task automatic tick_at(input logic [twq_pkg::TIME_W-1:0] now);
        send_item(twq_pkg::OP_TICK, rand_id(), $urandom, rand_prio(63), now);
    endtask

    task automatic test_directed();
        tick_at('0);
        tick_at('1);
        sleep_task_on(0, '0, 0);
        sleep_task_on(63, '1, 63);
        sleep_task_on(5, 100, 10);
        sleep_task_on(6, 100, 40);
        sleep_task_on(7, 100, 40);
        sleep_task_on(8, 100, 10);
        sleep_task_on(9, 50, 0);
        tick_at('0);
        tick_at(99);
        tick_at(100);
        sleep_task_on(21, 7, 63);
        sleep_task_on(22, 7, 0);
        sleep_task_on(23, 6, 0);
        tick_at(5);
        tick_at(10);
        tick_at(32'hFFFF_FFFE);
        tick_at('1);
        tick_at('1);
    endtask

    task automatic test_queue_full();
        for (int i = 0; i < twq_pkg::QUEUE_DEPTH + 3; i++)
            sleep_task_on(rand_id(), $urandom_range(0, 1000), rand_prio(63));
        tick_at(1000);
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        @(negedge clk);
        hold_req = 300;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 3 == 2)
                tick_at($urandom_range(0, 400));
            else
                sleep_task_on(rand_id(), $urandom_range(0, 500), rand_prio(63));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random(input int count);
        int r;
        clock_now = $urandom;
        for (int n = 0; n < count; n++)
        begin
            idle_on = !(n >= count / 2 && n < count / 2 + 40);
            r = $urandom_range(0, 99);
            if (r < 45)
                sleep_task_on(rand_id(), clock_now + $urandom_range(0, 150), rand_prio(63));
            else if (r < 60)
                sleep_task_on(rand_id(), clock_now + $urandom_range(0, 4), rand_prio(3));
            else if (r < 88)
            begin
                clock_now = clock_now + $urandom_range(0, 60);
                tick_at(clock_now);
            end
            else if (r < 95)
                sleep_task_on(rand_id(), $urandom, rand_prio(63));
            else
                tick_at($urandom);
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_queue_full();
        test_backpressure();
        test_random(240);
        @(negedge clk);
        push <= 1'b0;
        while (wakeups_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d sleeps (%0d dropped on a full queue) and %0d ticks",
                 n_sleep, n_dropped, n_tick);
        $display("woke %0d tasks, %0d ticks found nothing due, %0d results checked",
                 n_woken, n_idle_tick, n_checked);
        if (errors == 0)
            $display("timed_wake_queue_core regression: pass");
        else
            $display("timed_wake_queue_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
design/twq_pkg.sv
design/twq_ram.sv
design/twq_front.sv
design/twq_result_q.sv
design/twq_engine.sv
design/timed_wake_queue_core.sv
sim/tb.sv
